// ===== src/frs_pkg.sv =====
// Shared types and constants of the FASTA record splitter.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package frs_pkg;

    // Input operations.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_DATA  = 2'd1;
    localparam logic [1:0] OP_END   = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_SEQ   = 2'd0;
    localparam logic [1:0] KIND_HDR   = 2'd1;
    localparam logic [1:0] KIND_INDEX = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 8;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EOS_ENABLE    = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INITIAL_EOS   = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EOS_CHARACTER = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EOS_LENGTH    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UPPERCASE     = 3'd4;

    // Register reset values.
    localparam logic       RST_EOS_ENABLE    = 1'b1;
    localparam logic       RST_INITIAL_EOS   = 1'b1;
    localparam logic [7:0] RST_EOS_CHARACTER = 8'd10;
    localparam logic [1:0] RST_EOS_LENGTH    = 2'd1;
    localparam logic       RST_UPPERCASE     = 1'b1;

    // Character constants.
    localparam logic [7:0] CHAR_GT    = 8'h3E;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] PRINT_LO   = 8'd33;
    localparam logic [7:0] PRINT_HI   = 8'd126;
    localparam logic [7:0] LOWER_A    = 8'h61;
    localparam logic [7:0] LOWER_Z    = 8'h7A;
    localparam logic [7:0] CASE_DIFF  = 8'd32;
    localparam logic [1:0] LONG_MARK  = 2'd3;

    localparam int OFFSET_BITS = 48;

    typedef logic [OFFSET_BITS-1:0] offset_t;

    // One burst of results: an optional byte, up to three markers, an optional index record.
    typedef struct packed {
        logic       has_byte;
        logic       byte_hdr;
        logic [7:0] byte_val;
        logic [1:0] n_marks;
        logic       has_index;
        offset_t    seq_off;
        offset_t    hdr_off;
    } cmd_t;

endpackage
`default_nettype wire

// ===== src/frs_in_if.sv =====
// Input channel of the FASTA record splitter: operation and raw byte.
// Depends on frs_pkg.
`default_nettype none
interface frs_in_if
    import frs_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] in_byte;

    modport source (output valid, output operation, output in_byte, input ready);
    modport sink (input valid, input operation, input in_byte, output ready);
endinterface
`default_nettype wire

// ===== src/frs_out_if.sv =====
// Result channel of the FASTA record splitter: bytes and index records.
// Depends on frs_pkg.
`default_nettype none
interface frs_out_if
    import frs_pkg::*;
;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] out_byte;
    offset_t    sequence_offset;
    offset_t    header_offset;
    logic       last;

    modport source (output valid, output kind, output out_byte, output sequence_offset,
                    output header_offset, output last, input ready);
    modport sink (input valid, input kind, input out_byte, input sequence_offset,
                  input header_offset, input last, output ready);
endinterface
`default_nettype wire

// ===== src/frs_front.sv =====
// Front end: configuration registers, parse state and position counters.
// Turns each accepted beat that yields results into one burst command. Depends on frs_pkg, frs_in_if.
`default_nettype none
module frs_front
    import frs_pkg::*;
#(
    parameter int POSITION_BITS = 48
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    frs_in_if.sink                         stream,
    input  wire logic                      full,
    output logic                           push,
    output cmd_t                           cmd
);

    localparam int WIDE = (POSITION_BITS > OFFSET_BITS) ? POSITION_BITS : OFFSET_BITS;

    logic       eos_enable_reg;
    logic       initial_eos_reg;
    logic [7:0] eos_character_reg;
    logic [1:0] eos_length_reg;
    logic       uppercase_reg;

    logic hdr_line_reg, hdr_line_next;
    logic seq_body_reg, seq_body_next;
    logic line_start_reg, line_start_next;
    logic skip_reg, skip_next;
    logic [POSITION_BITS-1:0] seq_count_reg, hdr_count_reg;
    logic [POSITION_BITS-1:0] seq_base, hdr_base, seq_sat, hdr_sat;
    logic [POSITION_BITS:0]   seq_sum, hdr_sum;
    logic [WIDE-1:0]          seq_wide, hdr_wide;

    logic       accept;
    logic       clear;
    logic [1:0] seq_inc;
    logic       hdr_inc;
    logic [1:0] mark_n;
    logic       line_end;
    logic       printable;
    logic [7:0] b;
    logic [7:0] seq_char;

    assign stream.ready = !full;
    assign accept       = stream.valid && stream.ready;
    assign b            = stream.in_byte;
    assign line_end     = (b == CHAR_LF) || (b == CHAR_CR);
    assign printable    = (b >= PRINT_LO) && (b <= PRINT_HI);
    assign mark_n       = (eos_length_reg == LONG_MARK) ? 2'd3 : 2'd1;
    assign seq_char     = (uppercase_reg && b >= LOWER_A && b <= LOWER_Z) ? b - CASE_DIFF : b;

    always_comb
    begin
        hdr_line_next   = hdr_line_reg;
        seq_body_next   = seq_body_reg;
        line_start_next = line_start_reg;
        skip_next       = skip_reg;
        clear           = 1'b0;
        seq_inc         = 2'd0;
        hdr_inc         = 1'b0;
        cmd.has_byte    = 1'b0;
        cmd.byte_hdr    = 1'b0;
        cmd.byte_val    = 8'd0;
        cmd.n_marks     = 2'd0;
        cmd.has_index   = 1'b0;
        case (stream.operation)
            OP_START:
            begin
                clear           = 1'b1;
                hdr_line_next   = 1'b0;
                seq_body_next   = 1'b0;
                line_start_next = 1'b1;
                skip_next       = 1'b0;
                if (initial_eos_reg)
                begin
                    cmd.n_marks = mark_n;
                end
                seq_inc       = cmd.n_marks;
                cmd.has_index = 1'b1;
            end
            OP_DATA:
            begin
                skip_next = 1'b0;
                // A LF straight after a CR belongs to the same line end.
                if (!(skip_reg && b == CHAR_LF))
                begin
                    if (line_start_reg && b == CHAR_GT)
                    begin
                        if (seq_body_reg)
                        begin
                            if (eos_enable_reg)
                            begin
                                cmd.n_marks = mark_n;
                            end
                            seq_inc       = cmd.n_marks;
                            cmd.has_index = 1'b1;
                        end
                        hdr_line_next   = 1'b1;
                        seq_body_next   = 1'b0;
                        line_start_next = 1'b0;
                    end
                    else if (hdr_line_reg)
                    begin
                        cmd.has_byte = 1'b1;
                        cmd.byte_hdr = 1'b1;
                        hdr_inc      = 1'b1;
                        if (line_end)
                        begin
                            cmd.byte_val    = CHAR_LF;
                            hdr_line_next   = 1'b0;
                            seq_body_next   = 1'b1;
                            line_start_next = 1'b1;
                            skip_next       = (b == CHAR_CR);
                        end
                        else
                        begin
                            cmd.byte_val    = b;
                            line_start_next = 1'b0;
                        end
                    end
                    else if (seq_body_reg)
                    begin
                        if (line_end)
                        begin
                            line_start_next = 1'b1;
                            skip_next       = (b == CHAR_CR);
                        end
                        else
                        begin
                            line_start_next = 1'b0;
                            if (printable)
                            begin
                                cmd.has_byte = 1'b1;
                                cmd.byte_val = seq_char;
                                seq_inc      = 2'd1;
                            end
                        end
                    end
                end
            end
            OP_END:
            begin
                if (hdr_line_reg)
                begin
                    cmd.has_byte  = 1'b1;
                    cmd.byte_hdr  = 1'b1;
                    cmd.byte_val  = CHAR_LF;
                    hdr_inc       = 1'b1;
                    cmd.has_index = 1'b1;
                end
                else if (seq_body_reg)
                begin
                    if (eos_enable_reg)
                    begin
                        cmd.n_marks = mark_n;
                    end
                    seq_inc       = cmd.n_marks;
                    cmd.has_index = 1'b1;
                end
                hdr_line_next   = 1'b0;
                seq_body_next   = 1'b0;
                line_start_next = 1'b1;
                skip_next       = 1'b0;
            end
            default:
            begin
            end
        endcase
        if (cmd.n_marks != 2'd0)
        begin
            cmd.byte_val = eos_character_reg;
        end

        // Saturating counters: the carry out of the add marks an overflow.
        seq_base    = clear ? '0 : seq_count_reg;
        hdr_base    = clear ? '0 : hdr_count_reg;
        seq_sum     = {1'b0, seq_base} + (POSITION_BITS+1)'(seq_inc);
        hdr_sum     = {1'b0, hdr_base} + (POSITION_BITS+1)'(hdr_inc);
        seq_sat     = seq_sum[POSITION_BITS] ? '1 : seq_sum[POSITION_BITS-1:0];
        hdr_sat     = hdr_sum[POSITION_BITS] ? '1 : hdr_sum[POSITION_BITS-1:0];
        seq_wide    = WIDE'(seq_sat);
        hdr_wide    = WIDE'(hdr_sat);
        cmd.seq_off = seq_wide[OFFSET_BITS-1:0];
        cmd.hdr_off = hdr_wide[OFFSET_BITS-1:0];
    end

    assign push = accept && (cmd.has_byte || cmd.n_marks != 2'd0 || cmd.has_index);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eos_enable_reg    <= RST_EOS_ENABLE;
            initial_eos_reg   <= RST_INITIAL_EOS;
            eos_character_reg <= RST_EOS_CHARACTER;
            eos_length_reg    <= RST_EOS_LENGTH;
            uppercase_reg     <= RST_UPPERCASE;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_EOS_ENABLE:    eos_enable_reg    <= cfg_data[0];
                REG_INITIAL_EOS:   initial_eos_reg   <= cfg_data[0];
                REG_EOS_CHARACTER: eos_character_reg <= cfg_data[7:0];
                REG_EOS_LENGTH:    eos_length_reg    <= cfg_data[1:0];
                REG_UPPERCASE:     uppercase_reg     <= cfg_data[0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_line_reg   <= 1'b0;
            seq_body_reg   <= 1'b0;
            line_start_reg <= 1'b1;
            skip_reg       <= 1'b0;
            seq_count_reg  <= '0;
            hdr_count_reg  <= '0;
        end
        else if (accept)
        begin
            hdr_line_reg   <= hdr_line_next;
            seq_body_reg   <= seq_body_next;
            line_start_reg <= line_start_next;
            skip_reg       <= skip_next;
            seq_count_reg  <= seq_sat;
            hdr_count_reg  <= hdr_sat;
        end
    end

endmodule
`default_nettype wire

// ===== src/frs_queue.sv =====
// Short command queue between the front end and the result sequencer.
// Depends on frs_pkg.
`default_nettype none
module frs_queue
    import frs_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  cmd_t      din,
    input  wire logic pop,
    output cmd_t      dout,
    output logic      full,
    output logic      empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

    cmd_t             slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout  = slots[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/frs_back.sv =====
// Result sequencer: expands one burst command into its result beats.
// Depends on frs_pkg and frs_out_if.
`default_nettype none
module frs_back
    import frs_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  cmd_t      cmd,
    input  wire logic empty,
    output logic      pop,
    frs_out_if.source records
);

    cmd_t       cur_reg;
    logic       cur_valid_reg;
    logic       byte_left_reg;
    logic [1:0] marks_left_reg;
    logic       index_left_reg;
    logic [2:0] remaining;
    logic       fire;
    logic       done;

    assign remaining = {2'b0, byte_left_reg} + {1'b0, marks_left_reg} + {2'b0, index_left_reg};
    assign fire      = records.valid && records.ready;
    assign done      = fire && records.last;
    assign pop       = (!cur_valid_reg || done) && !empty;

    assign records.valid = cur_valid_reg;
    assign records.last  = (remaining == 3'd1);

    always_comb
    begin
        records.sequence_offset = '0;
        records.header_offset   = '0;
        if (byte_left_reg)
        begin
            records.kind     = cur_reg.byte_hdr ? KIND_HDR : KIND_SEQ;
            records.out_byte = cur_reg.byte_val;
        end
        else if (marks_left_reg != 2'd0)
        begin
            records.kind     = KIND_SEQ;
            records.out_byte = cur_reg.byte_val;
        end
        else
        begin
            records.kind            = KIND_INDEX;
            records.out_byte        = 8'd0;
            records.sequence_offset = cur_reg.seq_off;
            records.header_offset   = cur_reg.hdr_off;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= 1'b0;
            byte_left_reg  <= 1'b0;
            marks_left_reg <= 2'd0;
            index_left_reg <= 1'b0;
        end
        else if (pop)
        begin
            cur_valid_reg  <= 1'b1;
            byte_left_reg  <= cmd.has_byte;
            marks_left_reg <= cmd.n_marks;
            index_left_reg <= cmd.has_index;
        end
        else if (done)
        begin
            cur_valid_reg  <= 1'b0;
            byte_left_reg  <= 1'b0;
            marks_left_reg <= 2'd0;
            index_left_reg <= 1'b0;
        end
        else if (fire)
        begin
            if (byte_left_reg)
            begin
                byte_left_reg <= 1'b0;
            end
            else if (marks_left_reg != 2'd0)
            begin
                marks_left_reg <= marks_left_reg - 2'd1;
            end
            else
            begin
                index_left_reg <= 1'b0;
            end
        end
    end

`ifndef SYNTH
    a_valid_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        cur_valid_reg |-> remaining != 3'd0)
        else $error("result valid with no beats left in the burst");

    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !records.last) |=> cur_valid_reg && remaining == $past(remaining) - 3'd1)
        else $error("burst lost a beat after a non-final beat");

    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("command taken from an empty queue");

    a_drain_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (done && empty) |=> !cur_valid_reg)
        else $error("result still valid after the final beat with nothing queued");
`endif

endmodule
`default_nettype wire

// ===== src/fasta_record_splitter_unit.sv =====
// FASTA record splitter: takes one stream beat (start, data byte or end) per cycle while the
// command queue has room, and produces sequence bytes, header bytes and index records, one
// result beat per cycle while the result side is ready. An input beat is accepted whenever
// the command queue (QUEUE_DEPTH entries) has room; a burst of up to four results (markers plus
// an index record) holds the result side until it is out, and the queue absorbs the difference
// until it fills. Each command is registered in a queue slot, then in the sequencer's cur_reg.
// Position counters are POSITION_BITS wide and saturate; offsets are output on 48 bits.
// Depends on frs_pkg, frs_in_if, frs_out_if, frs_front, frs_queue and frs_back.
`default_nettype none
module fasta_record_splitter_unit
    import frs_pkg::*;
#(
    parameter int POSITION_BITS = 48,
    parameter int QUEUE_DEPTH   = 4
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_wr_en,
    input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [CFG_DATA_BITS-1:0]  cfg_data,
    frs_in_if.sink                         stream,
    frs_out_if.source                      records
);

    cmd_t push_cmd;
    cmd_t head_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    frs_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stream    (stream),
        .full      (full),
        .push      (push),
        .cmd       (push_cmd)
    );

    frs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (push_cmd),
        .pop   (pop),
        .dout  (head_cmd),
        .full  (full),
        .empty (empty)
    );

    frs_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (head_cmd),
        .empty   (empty),
        .pop     (pop),
        .records (records)
    );

endmodule
`default_nettype wire

// ===== sim/fasta_record_splitter_unit_test.sv =====
// Self-checking bench for fasta_record_splitter_unit: FASTA streams, noise and config changes.
// Depends on frs_pkg, frs_in_if, frs_out_if and the unit; expected records come from
// a behavioural copy of the parser held in the scoreboard class below.
`default_nettype none
module fasta_record_splitter_unit_test
    import frs_pkg::*;
;

    localparam int POS_W = 48;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SETTLE_CYCLES = 12;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] out_byte;
        offset_t    seq_off;
        offset_t    hdr_off;
        logic       last;
    } record_t;

    // Tracks the parser state and queues the records each accepted beat should produce.
    class fasta_split_scoreboard;
        bit         eos_on, eos_first, upcase;
        logic [7:0] mark_char;
        logic [1:0] mark_len;
        bit         in_hdr, in_seq, line_start, drop_lf;
        logic [POS_W-1:0] seq_pos, hdr_pos;
        record_t    burst[$];
        record_t    awaited_records[$];
        int         failures;

        function new();
            eos_on = RST_EOS_ENABLE;
            eos_first = RST_INITIAL_EOS;
            mark_char = RST_EOS_CHARACTER;
            mark_len = RST_EOS_LENGTH;
            upcase = RST_UPPERCASE;
            clear_parse();
            seq_pos = '0;
            hdr_pos = '0;
            failures = 0;
        endfunction

        function void set_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                REG_EOS_ENABLE:    eos_on = val[0];
                REG_INITIAL_EOS:   eos_first = val[0];
                REG_EOS_CHARACTER: mark_char = val;
                REG_EOS_LENGTH:    mark_len = val[1:0];
                REG_UPPERCASE:     upcase = val[0];
                default: ;
            endcase
        endfunction

        function void clear_parse();
            in_hdr = 1'b0;
            in_seq = 1'b0;
            line_start = 1'b1;
            drop_lf = 1'b0;
        endfunction

        function logic [POS_W-1:0] bump(logic [POS_W-1:0] v);
            return (&v) ? v : v + 1'b1;
        endfunction

        function void add(logic [1:0] kind, logic [7:0] b, offset_t so, offset_t ho);
            record_t r;
            r.kind = kind;
            r.out_byte = b;
            r.seq_off = so;
            r.hdr_off = ho;
            r.last = 1'b0;
            burst = {burst, r};
        endfunction

        function void add_markers();
            int n;
            n = (mark_len == LONG_MARK) ? 3 : 1;
            for (int i = 0; i < n; i++) begin
                add(KIND_SEQ, mark_char, '0, '0);
                seq_pos = bump(seq_pos);
            end
        endfunction

        function void add_index();
            add(KIND_INDEX, 8'd0, offset_t'(seq_pos), offset_t'(hdr_pos));
        endfunction

        function void parse_byte(logic [7:0] b);
            bit line_end;
            line_end = (b == CHAR_LF) || (b == CHAR_CR);
            if (drop_lf) begin
                drop_lf = 1'b0;
                if (b == CHAR_LF)
                    return;
            end
            if (line_start && b == CHAR_GT) begin
                if (in_seq) begin
                    if (eos_on)
                        add_markers();
                    add_index();
                end
                in_hdr = 1'b1;
                in_seq = 1'b0;
                line_start = 1'b0;
            end else if (in_hdr) begin
                // Any line end closes the header and is written out as LF.
                add(KIND_HDR, line_end ? CHAR_LF : b, '0, '0);
                hdr_pos = bump(hdr_pos);
                if (line_end) begin
                    in_hdr = 1'b0;
                    in_seq = 1'b1;
                    line_start = 1'b1;
                    drop_lf = (b == CHAR_CR);
                end else begin
                    line_start = 1'b0;
                end
            end else if (in_seq) begin
                if (line_end) begin
                    line_start = 1'b1;
                    drop_lf = (b == CHAR_CR);
                end else if (b < PRINT_LO || b > PRINT_HI) begin
                    line_start = 1'b0;
                end else begin
                    if (upcase && b >= LOWER_A && b <= LOWER_Z)
                        b = b - CASE_DIFF;
                    add(KIND_SEQ, b, '0, '0);
                    seq_pos = bump(seq_pos);
                    line_start = 1'b0;
                end
            end
        endfunction

        function void note_beat(logic [1:0] op, logic [7:0] b);
            record_t r;
            burst.delete();
            case (op)
                OP_START: begin
                    clear_parse();
                    seq_pos = '0;
                    hdr_pos = '0;
                    if (eos_first)
                        add_markers();
                    add_index();
                end
                OP_DATA: parse_byte(b);
                OP_END: begin
                    if (in_hdr) begin
                        add(KIND_HDR, CHAR_LF, '0, '0);
                        hdr_pos = bump(hdr_pos);
                        add_index();
                    end else if (in_seq) begin
                        if (eos_on)
                            add_markers();
                        add_index();
                    end
                    clear_parse();
                end
                default: ;
            endcase
            for (int i = 0; i < burst.size(); i++) begin
                r = burst[i];
                r.last = (i == burst.size() - 1);
                awaited_records = {awaited_records, r};
            end
        endfunction

        function void check_record(record_t got);
            record_t want;
            if (awaited_records.size() == 0) begin
                $error("record beat with nothing awaited: kind %0d byte %0d", got.kind,
                       got.out_byte);
                failures++;
                return;
            end
            want = awaited_records.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                failures++;
            end
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected %0d, got %0d", want.out_byte, got.out_byte);
                failures++;
            end
            if (got.seq_off !== want.seq_off) begin
                $error("sequence_offset: expected %0d, got %0d", want.seq_off, got.seq_off);
                failures++;
            end
            if (got.hdr_off !== want.hdr_off) begin
                $error("header_offset: expected %0d, got %0d", want.hdr_off, got.hdr_off);
                failures++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                failures++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    frs_in_if  stream_if ();
    frs_out_if records_if ();

    fasta_record_splitter_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .stream    (stream_if),
        .records   (records_if)
    );

    fasta_split_scoreboard sb = new();

    bit steady = 1'b0;
    int hold_request = 0;
    int items_sent = 0;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        sb.set_reg(idx, val);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_setting(bit en, bit first, logic [7:0] ch, logic [1:0] len, bit up);
        write_reg(REG_EOS_ENABLE, CFG_DATA_BITS'(en));
        write_reg(REG_INITIAL_EOS, CFG_DATA_BITS'(first));
        write_reg(REG_EOS_CHARACTER, ch);
        write_reg(REG_EOS_LENGTH, CFG_DATA_BITS'(len));
        write_reg(REG_UPPERCASE, CFG_DATA_BITS'(up));
    endtask

    task automatic send_beat(logic [1:0] op, logic [7:0] b);
        if (!steady) begin
            while ($urandom_range(0, 99) < 21) begin
                @(negedge clk);
                stream_if.valid <= 1'b0;
            end
        end
        @(negedge clk);
        stream_if.valid <= 1'b1;
        stream_if.operation <= op;
        stream_if.in_byte <= b;
        do
            @(posedge clk);
        while (stream_if.ready !== 1'b1);
        sb.note_beat(op, b);
        if (op != OP_UNUSED)
            items_sent++;
    endtask

    function automatic logic [7:0] seq_char();
        case ($urandom_range(0, 9))
            0: return 8'h41;
            1: return 8'h63;
            2: return 8'h47;
            3: return 8'h74;
            4: return 8'h6E;
            5: return LOWER_A + 8'($urandom_range(0, 25));
            6, 7: return 8'($urandom_range(PRINT_LO, PRINT_HI));
            8: return 8'($urandom_range(0, 255));
            default: return ($urandom_range(0, 1) != 0) ? 8'h20 : 8'h09;
        endcase
    endfunction

    task automatic send_line_end();
        case ($urandom_range(0, 3))
            0, 1: send_beat(OP_DATA, CHAR_LF);
            2: send_beat(OP_DATA, CHAR_CR);
            default: begin
                send_beat(OP_DATA, CHAR_CR);
                send_beat(OP_DATA, CHAR_LF);
            end
        endcase
    endtask

    task automatic send_record();
        logic [7:0] b;
        int nlines;
        send_beat(OP_DATA, CHAR_GT);
        repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom_range(0, 255));
            if (b == CHAR_LF || b == CHAR_CR)
                b = 8'h48;
            send_beat(OP_DATA, b);
        end
        send_line_end();
        nlines = $urandom_range(0, 3);
        repeat (nlines) begin
            repeat ($urandom_range(0, 10))
                send_beat(OP_DATA, seq_char());
            send_line_end();
        end
    endtask

    task automatic settle();
        @(negedge clk);
        stream_if.valid <= 1'b0;
        while (sb.awaited_records.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One stream of well-formed records with random content, sprinkled with noise beats.
    task automatic run_stream(int target);
        items_sent = 0;
        send_beat(OP_START, 8'($urandom_range(0, 255)));
        while (items_sent < target) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 3))
                    send_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end else begin
                send_record();
            end
        end
        send_beat(OP_END, 8'($urandom_range(0, 255)));
        settle();
    endtask

    // Result side: random stalls, a steady stretch, and one long hold-off on request.
    initial begin
        int hold;
        hold = 0;
        records_if.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request > 0) begin
                hold = hold_request;
                hold_request = 0;
            end
            if (hold > 0) begin
                hold--;
                records_if.ready <= 1'b0;
            end else if (steady) begin
                records_if.ready <= 1'b1;
            end else begin
                records_if.ready <= ($urandom_range(0, 99) >= 21);
            end
        end
    end

    always @(posedge clk) begin
        record_t got;
        if (rst_n === 1'b1 && records_if.valid === 1'b1 && records_if.ready === 1'b1) begin
            got.kind = records_if.kind;
            got.out_byte = records_if.out_byte;
            got.seq_off = records_if.sequence_offset;
            got.hdr_off = records_if.header_offset;
            got.last = records_if.last;
            sb.check_record(got);
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        stream_if.valid = 1'b0;
        stream_if.operation = OP_DATA;
        stream_if.in_byte = 8'd0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        apply_setting(1'b1, 1'b1, 8'd10, 2'd1, 1'b1);

        // Directed stream: pre-header bytes, CR handling, printable limits, ignored opcode,
        // end inside a header, data after end, end inside a sequence.
        send_beat(OP_START, 8'hFF);
        send_beat(OP_DATA, 8'h78);
        send_beat(OP_DATA, CHAR_GT);
        send_beat(OP_DATA, 8'h00);
        send_beat(OP_DATA, 8'hFF);
        send_beat(OP_DATA, CHAR_CR);
        send_beat(OP_DATA, CHAR_LF);
        send_beat(OP_DATA, LOWER_A);
        send_beat(OP_DATA, 8'd33);
        send_beat(OP_DATA, 8'd126);
        send_beat(OP_DATA, 8'd32);
        send_beat(OP_DATA, 8'd127);
        send_beat(OP_DATA, CHAR_CR);
        send_beat(OP_DATA, 8'h67);
        send_beat(OP_DATA, CHAR_LF);
        send_beat(OP_DATA, CHAR_GT);
        send_beat(OP_DATA, 8'h71);
        send_beat(OP_UNUSED, 8'h5A);
        send_beat(OP_END, 8'h00);
        send_beat(OP_DATA, CHAR_GT);
        send_beat(OP_DATA, CHAR_LF);
        send_beat(OP_DATA, 8'h74);
        send_beat(OP_DATA, LOWER_Z);
        send_beat(OP_END, 8'hAA);
        settle();

        apply_setting(1'b0, 1'b1, 8'd0, 2'd3, 1'b0);
        run_stream(65);

        // No idling on either side for this whole stream.
        steady = 1'b1;
        apply_setting(1'b1, 1'b0, 8'd255, 2'd3, 1'b1);
        run_stream(65);
        steady = 1'b0;

        // The result side holds off long enough for the unit to back up into its input.
        apply_setting(1'b1, 1'b1, 8'h24, 2'd0, 1'b0);
        hold_request = 80;
        run_stream(65);

        apply_setting(1'b0, 1'b0, 8'($urandom_range(0, 255)), 2'd2, 1'b1);
        run_stream(65);

        if (sb.failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
`default_nettype wire
